### sv/sirm_pkg.sv
package sirm_pkg;

   localparam int MAX_BLOCKS_DEF = 64;
   localparam int BLOCK_SIZE = 1024;
   localparam int BLOCK_SHIFT = $clog2(BLOCK_SIZE);

   localparam int BN_W = 21;
   localparam int ID_W = 32;
   localparam int IDX_W = 17;
   localparam int ST_W = 2;

   localparam logic CMD_REGISTER = 1'b0;
   localparam logic CMD_MAP = 1'b1;

   localparam logic [ST_W-1:0] STATUS_OK = 2'd0;
   localparam logic [ST_W-1:0] STATUS_INVALID = 2'd1;
   localparam logic [ST_W-1:0] STATUS_FULL = 2'd2;

   typedef struct packed {
      logic [BN_W-1:0] key;
      logic insert;
   } cell_ctl_type;

   typedef struct packed {
      logic [BN_W-1:0] value;
      logic valid;
      logic lt;
   } cell_link_type;

endpackage

### sv/sirm_req_if.sv
interface sirm_req_if;
   import sirm_pkg::*;

   logic valid;
   logic ready;
   logic cmd;
   logic [BN_W-1:0] block_number;
   logic signed [ID_W-1:0] shape_id;

   modport source(output valid, output cmd, output block_number, output shape_id,
                  input ready);
   modport sink(input valid, input cmd, input block_number, input shape_id,
                output ready);
endinterface

### sv/sirm_rsp_if.sv
interface sirm_rsp_if;
   import sirm_pkg::*;

   logic valid;
   logic ready;
   logic [IDX_W-1:0] local_index;
   logic [ST_W-1:0] status;

   modport source(output valid, output local_index, output status, input ready);
   modport sink(input valid, input local_index, input status, output ready);
endinterface

### sv/sirm_cell.sv
module sirm_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  sirm_pkg::cell_ctl_type ctl,
   input  sirm_pkg::cell_link_type left,
   output sirm_pkg::cell_link_type self,
   output logic                   eq
);
   import sirm_pkg::*;

   logic [BN_W-1:0] value_ff;
   logic [BN_W-1:0] value_in;
   logic valid_ff;
   logic valid_in;
   logic lt;

   assign lt = valid_ff && (value_ff < ctl.key);
   assign eq = valid_ff && (value_ff == ctl.key);

   assign self.value = value_ff;
   assign self.valid = valid_ff;
   assign self.lt = lt;

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctl.insert && !lt) begin
         if (left.lt) begin
            value_in = ctl.key;
            valid_in = 1'b1;
         end else begin
            value_in = left.value;
            valid_in = left.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

### sv/shape_id_block_rank_mapper.sv
// Each accepted request word is decoded into the a_ stage registers, and its
// response into the output registers; one word per cycle unless rsp_ch stalls.
// The key is compared against all cells of the sorted chain at once; they shift on insert.
// Reset is synchronous and active high; it empties the block set at once and
// drops any word in flight.
module shape_id_block_rank_mapper #(
   parameter int MAX_BLOCKS = sirm_pkg::MAX_BLOCKS_DEF
) (
   input logic         clock,
   input logic         reset,
   sirm_req_if.sink    req_ch,
   sirm_rsp_if.source  rsp_ch
);
   import sirm_pkg::*;

   localparam int RANK_W = $clog2(MAX_BLOCKS + 1);
   localparam int SUM_W = RANK_W + BLOCK_SHIFT + 1;

   logic a_valid_ff;
   logic [BN_W-1:0] a_key_ff;
   logic a_lookup_ff;
   logic a_map_ff;
   logic a_invalid_ff;
   logic [BLOCK_SHIFT:0] a_off_ff;

   logic o_valid_ff;
   logic [IDX_W-1:0] o_index_ff;
   logic [ST_W-1:0] o_status_ff;

   logic o_free;
   logic a_fire;
   logic in_fire;

   logic [ID_W-1:0] id_m1;
   logic [BN_W-1:0] key_in;
   logic lookup_in;
   logic map_in;
   logic invalid_in;
   logic [BLOCK_SHIFT:0] off_in;

   cell_ctl_type ctl;
   cell_link_type links [MAX_BLOCKS+1];
   logic [MAX_BLOCKS-1:0] eq_vec;
   logic found;
   logic full;
   logic [RANK_W-1:0] rank;
   logic [SUM_W-1:0] sum;
   logic [IDX_W-1:0] index_in;
   logic [ST_W-1:0] status_in;

   assign o_free = !o_valid_ff || rsp_ch.ready;
   assign a_fire = a_valid_ff && o_free;
   assign req_ch.ready = !a_valid_ff || o_free;
   assign in_fire = req_ch.valid && req_ch.ready;

   assign id_m1 = req_ch.shape_id - ID_W'(1);

   always_comb begin
      off_in = {1'b0, id_m1[BLOCK_SHIFT-1:0]} + (BLOCK_SHIFT+1)'(1);
      if (req_ch.cmd == CMD_MAP) begin
         map_in = 1'b1;
         invalid_in = req_ch.shape_id[ID_W-1] || (req_ch.shape_id == '0);
         key_in = id_m1[BLOCK_SHIFT+BN_W-1:BLOCK_SHIFT];
      end else begin
         map_in = 1'b0;
         invalid_in = (req_ch.block_number == '0);
         key_in = req_ch.block_number;
      end
      lookup_in = !invalid_in;
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         a_key_ff <= key_in;
         a_lookup_ff <= lookup_in;
         a_map_ff <= map_in;
         a_invalid_ff <= invalid_in;
         a_off_ff <= off_in;
      end
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         a_valid_ff <= req_ch.valid;
      end
   end

   assign links[0].value = '0;
   assign links[0].valid = 1'b0;
   assign links[0].lt = 1'b1;

   assign found = |eq_vec;
   assign full = links[MAX_BLOCKS].valid;
   assign ctl.key = a_key_ff;
   assign ctl.insert = a_fire && a_lookup_ff && !found && !full;

   genvar g;
   generate
      for (g = 0; g < MAX_BLOCKS; g++) begin : g_cell
         sirm_cell u_cell (
            .clock(clock),
            .reset(reset),
            .ctl(ctl),
            .left(links[g]),
            .self(links[g+1]),
            .eq(eq_vec[g])
         );
      end
   endgenerate

   // The less-than flags form a thermometer code, so its single edge is the rank.
   always_comb begin
      rank = '0;
      for (int i = 0; i < MAX_BLOCKS; i++) begin
         if (links[i].lt && !links[i+1].lt) begin
            rank = rank | RANK_W'(i);
         end
      end
      if (links[MAX_BLOCKS].lt) begin
         rank = rank | RANK_W'(MAX_BLOCKS);
      end
   end

   assign sum = SUM_W'({rank, {BLOCK_SHIFT{1'b0}}}) + SUM_W'(a_off_ff);

   always_comb begin
      if (a_invalid_ff) begin
         status_in = STATUS_INVALID;
      end else if (!found && full) begin
         status_in = STATUS_FULL;
      end else begin
         status_in = STATUS_OK;
      end
      if (a_invalid_ff || !a_map_ff) begin
         index_in = '0;
      end else begin
         index_in = IDX_W'(sum);
      end
   end

   always_ff @(posedge clock) begin
      if (a_fire) begin
         o_index_ff <= index_in;
         o_status_ff <= status_in;
      end
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (o_free) begin
         o_valid_ff <= a_valid_ff;
      end
   end

   assign rsp_ch.valid = o_valid_ff;
   assign rsp_ch.local_index = o_index_ff;
   assign rsp_ch.status = o_status_ff;

endmodule

### sv/sirm_checker.sv
module sirm_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [sirm_pkg::IDX_W-1:0]  local_index,
   input logic [sirm_pkg::ST_W-1:0]   status
);
   import sirm_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("Response word dropped while stalled.");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(local_index) && $stable(status))
      else $error("Response word changed while stalled.");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Response word present right after reset.");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (status == STATUS_OK || status == STATUS_INVALID ||
                     status == STATUS_FULL))
      else $error("Unknown status code.");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status == STATUS_INVALID) |-> (local_index == '0))
      else $error("Invalid word reported a nonzero index.");

endmodule

bind shape_id_block_rank_mapper sirm_checker u_sirm_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_ch.valid),
   .rsp_ready(rsp_ch.ready),
   .local_index(rsp_ch.local_index),
   .status(rsp_ch.status)
);
